// ===== hdl/icd_pkg.sv =====
// Shared types and constants for the bus clock divider search.
// Used by the divider unit, the top level and the port checker; no dependencies.
package icd_pkg;

   // field and datapath widths
   localparam int unsigned SYS_W  = 31;  // system clock register
   localparam int unsigned TGT_W  = 20;  // requested bus frequency
   localparam int unsigned DSR_W  = 36;  // widest divisor: 2 * target * (m+1) * 10 * 2^n
   localparam int unsigned PROD_W = 28;  // target * (m+1) * 10
   localparam int unsigned K_W    = 8;   // (m+1) * 10
   localparam int unsigned THP1_W = 9;   // half period plus one

   // limits and defaults
   localparam logic [TGT_W-1:0] TARGET_MAX   = 20'd1000000;
   localparam logic [TGT_W-1:0] ERR_INIT     = 20'd1000000;
   localparam logic [SYS_W-1:0] SYS_RESET    = 31'd100000000;
   localparam logic [7:0]       THP_DEFAULT  = 8'h18;
   localparam logic [3:0]       MDIV_DEFAULT = 4'd2;
   localparam logic [2:0]       NDIV_DEFAULT = 3'd0;
   localparam logic [3:0]       MDIV_TOP     = 4'd15;
   localparam logic [3:0]       MDIV_BOTTOM  = 4'd2;
   localparam logic [2:0]       NDIV_LAST    = 3'd7;
   localparam logic [7:0]       THP_MIN      = 8'd5;
   localparam logic [7:0]       THP_MAX      = 8'hff;
   // half period plus one must fall in this window
   localparam logic [31:0]      THP1_MIN     = 32'd6;
   localparam logic [31:0]      THP1_MAX     = 32'd256;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PAIR_MUL,
      ST_PAIR_GO,
      ST_PAIR_WAIT,
      ST_CAND,
      ST_CAND_MUL,
      ST_CAND_GO,
      ST_CAND_WAIT,
      ST_CAND_NEXT,
      ST_PAIR_NEXT,
      ST_DONE
   } icd_state_type;

endpackage

// ===== hdl/icd_div.sv =====
// Shared unsigned divider, restoring long division two quotient bits per cycle.
// Depends on icd_pkg for the operand widths.
module icd_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [icd_pkg::SYS_W-1:0]  dividend,
   input  logic [icd_pkg::DSR_W-1:0]  divisor,
   output logic                       done,
   output logic [icd_pkg::SYS_W-1:0]  quotient
);
   import icd_pkg::*;

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [3:0]         cnt_ff, cnt_in;
   logic [SYS_W-1:0]   rem_ff, rem_in;
   logic [SYS_W:0]     dvd_ff, dvd_in;
   logic [SYS_W-1:0]   dsr_ff, dsr_in;

   logic               too_big;
   logic [SYS_W:0]     r1, r2;
   logic               ge1, ge2;
   logic [SYS_W-1:0]   rem1, rem2;

   // a divisor above the dividend range gives a zero quotient at once
   assign too_big = |divisor[DSR_W-1:SYS_W];

   // two dependent restoring steps
   always_comb begin
      r1   = {rem_ff, dvd_ff[SYS_W]};
      ge1  = r1 >= {1'b0, dsr_ff};
      rem1 = ge1 ? SYS_W'(r1 - {1'b0, dsr_ff}) : r1[SYS_W-1:0];
      r2   = {rem1, dvd_ff[SYS_W-1]};
      ge2  = r2 >= {1'b0, dsr_ff};
      rem2 = ge2 ? SYS_W'(r2 - {1'b0, dsr_ff}) : r2[SYS_W-1:0];
   end

   // load on start, advance while busy
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         rem_in = '0;
         dsr_in = divisor[SYS_W-1:0];
         cnt_in = 4'd15;
         if (too_big) begin
            dvd_in  = '0;
            done_in = 1'b1;
         end else begin
            dvd_in  = {1'b0, dividend};
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in = rem2;
         dvd_in = {dvd_ff[SYS_W-2:0], ge1, ge2};
         cnt_in = cnt_ff - 4'd1;
         if (cnt_ff == 4'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = dvd_ff[SYS_W-1:0];

endmodule

// ===== hdl/i2c_clock_divider_search.sv =====
// Bus clock divider search: top level with sequencer, shared multiplier and divider.
// Depends on icd_pkg and icd_div.
//
// Usage: write the system clock in hertz through csr_write_enable/csr_write_data
// (reset value 100 MHz) while the block is idle. Offer a requested bus frequency
// on req_valid/req_target_bus_hz; one result transfer follows on rsp_valid with
// the half period, M and N dividers, the frequency error and a found flag.
// The search walks N from 0 to 7 and M from 15 down to 2. Every (N, M) pair takes
// one multiply and one division for the base half period (the division is cut short
// when the divisor exceeds the clock range), then a multiply and a division for each
// of the two candidates in range, while one out of range is skipped, and a step to
// the next pair. All 112 pairs are tried unless an exact match ends the search early;
// every division goes through the one divider.
// req_stall is high for the whole search; one item is handled at a time.
// The result sits in an output register, so a new request is taken while a
// stalled result still waits; if the next search ends first it holds until
// rsp_stall drops. Reset empties the output register, restores the clock
// register and returns the sequencer to idle with req_stall low.
module i2c_clock_divider_search (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [icd_pkg::SYS_W-1:0]  csr_write_data,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [icd_pkg::TGT_W-1:0]  req_target_bus_hz,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [7:0]                 rsp_half_period,
   output logic [3:0]                 rsp_m_divider,
   output logic [2:0]                 rsp_n_divider,
   output logic [icd_pkg::TGT_W-1:0]  rsp_error_hz,
   output logic                       rsp_found
);
   import icd_pkg::*;

   icd_state_type       state_ff, state_in;
   logic [SYS_W-1:0]    sys_ff;
   logic [TGT_W-1:0]    tgt_ff, tgt_in;
   logic [2:0]          n_ff, n_in;
   logic [3:0]          m_ff, m_in;
   logic                cand_ff, cand_in;
   logic [SYS_W-1:0]    q_ff, q_in;
   logic [THP1_W-1:0]   thp1_ff, thp1_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [7:0]          best_thp_ff, best_thp_in;
   logic [3:0]          best_m_ff, best_m_in;
   logic [2:0]          best_n_ff, best_n_in;
   logic [TGT_W-1:0]    delta_ff, delta_in;
   logic                found_ff, found_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          rsp_thp_ff;
   logic [3:0]          rsp_m_ff;
   logic [2:0]          rsp_n_ff;
   logic [TGT_W-1:0]    rsp_err_ff;
   logic                rsp_found_ff;

   logic                req_xfer;
   logic                out_load;
   logic [SYS_W-1:0]    sys_eff;
   logic [TGT_W-1:0]    tgt_sat;
   logic [4:0]          mp1;
   logic [K_W-1:0]      k;
   logic [TGT_W-1:0]    mul_a;
   logic [31:0]         thp1_wide;
   logic                div_start;
   logic [DSR_W-1:0]    div_divisor;
   logic                div_done;
   logic [SYS_W-1:0]    div_quot;
   logic [SYS_W-1:0]    diff;
   logic                better;

   // clock register, zero taken as one
   always_ff @(posedge clock) begin
      if (reset) begin
         sys_ff <= SYS_RESET;
      end else if (csr_write_enable) begin
         sys_ff <= csr_write_data;
      end
   end
   assign sys_eff = (sys_ff == '0) ? SYS_W'(1) : sys_ff;

   // saturate the request
   always_comb begin
      if (req_target_bus_hz == '0) begin
         tgt_sat = TGT_W'(1);
      end else if (req_target_bus_hz > TARGET_MAX) begin
         tgt_sat = TARGET_MAX;
      end else begin
         tgt_sat = req_target_bus_hz;
      end
   end

   // (m+1)*10 by shift and add, one shared multiplier
   assign mp1   = {1'b0, m_ff} + 5'd1;
   assign k     = K_W'({mp1, 3'b000}) + K_W'({mp1, 1'b0});
   assign mul_a = (state_ff == ST_PAIR_MUL) ? tgt_ff : TGT_W'(thp1_ff);

   // scale by 2^(n+1) on the way into the divider
   assign div_divisor = DSR_W'({{(DSR_W-PROD_W){1'b0}}, prod_ff} << ({1'b0, n_ff} + 4'd1));
   assign thp1_wide   = {1'b0, q_ff} + {31'd0, cand_ff};

   // error of the achieved frequency
   always_comb begin
      if (div_quot > SYS_W'(tgt_ff)) begin
         diff = div_quot - SYS_W'(tgt_ff);
      end else begin
         diff = SYS_W'(tgt_ff) - div_quot;
      end
      better = diff < SYS_W'(delta_ff);
   end

   icd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sys_eff),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign req_xfer = req_valid && !req_stall;
   assign out_load = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   // sequencer: next state and datapath updates
   always_comb begin
      state_in    = state_ff;
      tgt_in      = tgt_ff;
      n_in        = n_ff;
      m_in        = m_ff;
      cand_in     = cand_ff;
      q_in        = q_ff;
      thp1_in     = thp1_ff;
      prod_in     = prod_ff;
      best_thp_in = best_thp_ff;
      best_m_in   = best_m_ff;
      best_n_in   = best_n_ff;
      delta_in    = delta_ff;
      found_in    = found_ff;
      div_start   = 1'b0;
      req_stall   = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               tgt_in      = tgt_sat;
               n_in        = '0;
               m_in        = MDIV_TOP;
               best_thp_in = THP_DEFAULT;
               best_m_in   = MDIV_DEFAULT;
               best_n_in   = NDIV_DEFAULT;
               delta_in    = ERR_INIT;
               found_in    = 1'b0;
               state_in    = ST_PAIR_MUL;
            end
         end
         ST_PAIR_MUL: begin
            prod_in  = PROD_W'(mul_a) * PROD_W'(k);
            state_in = ST_PAIR_GO;
         end
         ST_PAIR_GO: begin
            div_start = 1'b1;
            state_in  = ST_PAIR_WAIT;
         end
         ST_PAIR_WAIT: begin
            if (div_done) begin
               q_in     = div_quot;
               cand_in  = 1'b0;
               state_in = ST_CAND;
            end
         end
         ST_CAND: begin
            // half period plus one is the quotient (lower) or one above it
            thp1_in = thp1_wide[THP1_W-1:0];
            if (thp1_wide >= THP1_MIN && thp1_wide <= THP1_MAX) begin
               state_in = ST_CAND_MUL;
            end else begin
               state_in = ST_CAND_NEXT;
            end
         end
         ST_CAND_MUL: begin
            prod_in  = PROD_W'(mul_a) * PROD_W'(k);
            state_in = ST_CAND_GO;
         end
         ST_CAND_GO: begin
            div_start = 1'b1;
            state_in  = ST_CAND_WAIT;
         end
         ST_CAND_WAIT: begin
            if (div_done) begin
               if (better) begin
                  delta_in    = diff[TGT_W-1:0];
                  best_thp_in = 8'(thp1_ff - THP1_W'(1));
                  best_m_in   = m_ff;
                  best_n_in   = n_ff;
                  found_in    = 1'b1;
               end
               state_in = ST_CAND_NEXT;
            end
         end
         ST_CAND_NEXT: begin
            if (!cand_ff) begin
               cand_in  = 1'b1;
               state_in = ST_CAND;
            end else begin
               state_in = ST_PAIR_NEXT;
            end
         end
         ST_PAIR_NEXT: begin
            // stop on an exact match or after the last pair
            if (delta_ff == '0 || (n_ff == NDIV_LAST && m_ff == MDIV_BOTTOM)) begin
               state_in = ST_DONE;
            end else begin
               if (m_ff == MDIV_BOTTOM) begin
                  m_in = MDIV_TOP;
                  n_in = n_ff + 3'd1;
               end else begin
                  m_in = m_ff - 4'd1;
               end
               state_in = ST_PAIR_MUL;
            end
         end
         ST_DONE: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // hold the result until the receiver takes it
   assign rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tgt_ff      <= tgt_in;
      n_ff        <= n_in;
      m_ff        <= m_in;
      cand_ff     <= cand_in;
      q_ff        <= q_in;
      thp1_ff     <= thp1_in;
      prod_ff     <= prod_in;
      best_thp_ff <= best_thp_in;
      best_m_ff   <= best_m_in;
      best_n_ff   <= best_n_in;
      delta_ff    <= delta_in;
      found_ff    <= found_in;
      if (out_load) begin
         rsp_thp_ff   <= best_thp_ff;
         rsp_m_ff     <= best_m_ff;
         rsp_n_ff     <= best_n_ff;
         rsp_err_ff   <= delta_ff;
         rsp_found_ff <= found_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_half_period = rsp_thp_ff;
   assign rsp_m_divider   = rsp_m_ff;
   assign rsp_n_divider   = rsp_n_ff;
   assign rsp_error_hz    = rsp_err_ff;
   assign rsp_found       = rsp_found_ff;

endmodule

// ===== hdl/icd_chk.sv =====
// Port-level checker for the bus clock divider search, bound to the top level.
// Depends on icd_pkg for limits and defaults.
module icd_chk (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic [7:0]                 rsp_half_period,
   input logic [3:0]                 rsp_m_divider,
   input logic [2:0]                 rsp_n_divider,
   input logic [icd_pkg::TGT_W-1:0]  rsp_error_hz,
   input logic                       rsp_found
);
   import icd_pkg::*;

   // reset leaves the block empty and ready
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !req_stall && !rsp_valid)
      else $error("block not idle after reset");

   // nothing found gives the defaults
   a_defaults: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |->
         rsp_half_period == THP_DEFAULT && rsp_m_divider == MDIV_DEFAULT &&
         rsp_n_divider == NDIV_DEFAULT && rsp_error_hz == ERR_INIT)
      else $error("defaults wrong when nothing found");

   // a found setting lies in range and beats the initial bound
   a_found_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |->
         rsp_half_period >= THP_MIN && rsp_m_divider >= MDIV_BOTTOM &&
         rsp_error_hz < ERR_INIT)
      else $error("found setting out of range");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_half_period) &&
         $stable(rsp_m_divider) && $stable(rsp_n_divider) &&
         $stable(rsp_error_hz) && $stable(rsp_found))
      else $error("stalled result changed");

endmodule

bind i2c_clock_divider_search icd_chk u_icd_chk (.*);
